// ===== design/sha_pkg.sv =====
// ---------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ---------------------------------------------------------------------------
package sha_pkg;

	localparam int WORD_W   = 32;
	localparam int NUM_HASH = 8;
	localparam int NUM_SCHED = 16;
	localparam int NUM_ROUNDS = 64;
	localparam int ROUND_W  = $clog2(NUM_ROUNDS);
	localparam int SLOT_W   = $clog2(NUM_SCHED);
	localparam int IDX_W    = $clog2(NUM_HASH);
	localparam int LEN_W    = 64;
	localparam int VALID_W  = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NUM_HASH-1:0][WORD_W-1:0] hash_t;

	localparam word_t       PAD_WORD    = 32'h8000_0000;
	localparam logic [7:0]  PAD_BYTE    = 8'h80;
	localparam logic [SLOT_W-1:0] LEN_HI_SLOT = 4'd14;
	localparam logic [SLOT_W-1:0] LAST_SLOT   = 4'd15;
	localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
	localparam logic [IDX_W-1:0]  LAST_IDX    = 3'd7;
	localparam logic [VALID_W-1:0] FULL_BYTES = 3'd4;
	localparam logic [LEN_W-1:0]  WORD_BITS   = 64'd32;

	localparam hash_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t ROUND_K [NUM_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	// requests from the sequencer to the round unit
	typedef struct packed {
		logic  push;
		word_t push_word;
		logic  start;
	} core_ctrl_t;

	typedef struct packed {
		logic done;
	} core_stat_t;

	function automatic word_t big_sig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ===== design/sha256_message_hasher.sv =====
// ---------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a stream of big-endian words with padding and length append;
// gives the eight digest words after the last word of a message.
// ---------------------------------------------------------------------------
// channel  dir  fields (tdata / tuser / tlast)
// s_*      in   message_word / valid_bytes / last_word
// m_*      out  digest_word / digest_index / digest_done
//
// a word that does not fill a block is shifted into the schedule; the
// sixteenth word of a block starts compression in the round unit, then the chain update.
// after a last word the padding words go in one a cycle, one or two blocks
// are compressed, then eight digest items are offered, one a cycle.
// s_tready is low from a block's last word until its compression ends, and
// during padding and digest output; m_tready low holds the current digest item.
// reset loads the initial hash values and clears length and slot counters.
// ---------------------------------------------------------------------------
module sha256_message_hasher
	import sha_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [WORD_W-1:0]  s_tdata,   // message_word
	input  logic [VALID_W-1:0] s_tuser,   // valid_bytes
	input  logic               s_tlast,   // last_word
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [WORD_W-1:0]  m_tdata,   // digest_word
	output logic [IDX_W-1:0]   m_tuser,   // digest_index
	output logic               m_tlast    // digest_done
);

	state_t              state_q, state_d;
	hash_t               chain_q;
	logic [LEN_W-1:0]    bitlen_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                pend80_q;
	logic                hi_done_q;
	logic                final_q;
	logic                padding_q;

	core_ctrl_t          ctrl;
	core_stat_t          stat;
	hash_t               work;

	logic                in_acc;
	logic                out_acc;
	logic [VALID_W-1:0]  vbytes;
	word_t               tail_word;
	logic [LEN_W-1:0]    add_bits;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// counts above four are taken as a full word
	assign vbytes = (s_tuser > FULL_BYTES) ? FULL_BYTES : s_tuser;

	always_comb begin
		case (vbytes)
			3'd0:    tail_word = PAD_WORD;
			3'd1:    tail_word = {s_tdata[31:24], PAD_BYTE, 16'd0};
			3'd2:    tail_word = {s_tdata[31:16], PAD_BYTE, 8'd0};
			3'd3:    tail_word = {s_tdata[31:8], PAD_BYTE};
			default: tail_word = s_tdata;
		endcase
	end

	assign add_bits = s_tlast ? {{(LEN_W-VALID_W-3){1'b0}}, vbytes, 3'b000} : WORD_BITS;

	sha_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.chain  (chain_q),
		.work   (work),
		.stat   (stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (slot_q == LAST_SLOT) begin
						state_d = ST_ROUND;
					end else if (s_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (slot_q == LAST_SLOT) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (stat.done) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (padding_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_acc && out_idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready       = 1'b0;
		m_tvalid       = 1'b0;
		ctrl.push      = 1'b0;
		ctrl.push_word = s_tdata;
		case (state_q)
			ST_IDLE: begin
				s_tready       = 1'b1;
				ctrl.push      = s_tvalid;
				ctrl.push_word = s_tlast ? tail_word : s_tdata;
			end
			ST_PAD: begin
				ctrl.push = 1'b1;
				if (pend80_q) begin
					ctrl.push_word = PAD_WORD;
				end else if (!hi_done_q) begin
					ctrl.push_word = (slot_q == LEN_HI_SLOT) ? bitlen_q[LEN_W-1:WORD_W] : '0;
				end else begin
					ctrl.push_word = bitlen_q[WORD_W-1:0];
				end
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
			end
			default: begin
				ctrl.push = 1'b0;
			end
		endcase
		ctrl.start = ctrl.push && (slot_q == LAST_SLOT);
	end

	assign m_tdata = chain_q[out_idx_q];
	assign m_tuser = out_idx_q;
	assign m_tlast = (out_idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			chain_q   <= INIT_HASH;
			bitlen_q  <= '0;
			slot_q    <= '0;
			out_idx_q <= '0;
			pend80_q  <= 1'b0;
			hi_done_q <= 1'b0;
			final_q   <= 1'b0;
			padding_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.push) begin
				slot_q <= slot_q + 1'b1;
			end
			if (in_acc) begin
				bitlen_q <= bitlen_q + add_bits;
				if (s_tlast) begin
					padding_q <= 1'b1;
					pend80_q  <= (vbytes == FULL_BYTES);
				end
			end
			if (state_q == ST_PAD) begin
				if (pend80_q) begin
					pend80_q <= 1'b0;
				end else if (!hi_done_q) begin
					hi_done_q <= (slot_q == LEN_HI_SLOT);
				end else begin
					final_q <= 1'b1;
				end
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < NUM_HASH; i++) begin
					chain_q[i] <= chain_q[i] + work[i];
				end
			end
			if (out_acc) begin
				out_idx_q <= out_idx_q + 1'b1;
				// back to the reset state for the next message
				if (out_idx_q == LAST_IDX) begin
					chain_q   <= INIT_HASH;
					bitlen_q  <= '0;
					slot_q    <= '0;
					hi_done_q <= 1'b0;
					final_q   <= 1'b0;
					padding_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== design/sha_core.sv =====
// ---------------------------------------------------------------------------
// sha_core
// Round unit: rolling message schedule, working variables and a round
// counter. One compression round per cycle while busy.
// ---------------------------------------------------------------------------
module sha_core
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctrl_t ctrl,
	input  hash_t      chain,
	output hash_t      work,
	output core_stat_t stat
);

	word_t              sched_q [NUM_SCHED];
	hash_t              work_q;
	logic [ROUND_W-1:0] round_q;
	logic               busy_q;

	word_t a, b, c, d, e, f, g, h;
	word_t t1, t2, ch, maj, w_next;

	always_comb begin
		a = work_q[0];
		b = work_q[1];
		c = work_q[2];
		d = work_q[3];
		e = work_q[4];
		f = work_q[5];
		g = work_q[6];
		h = work_q[7];
		ch  = (e & f) ^ (~e & g);
		maj = (a & b) ^ (a & c) ^ (b & c);
		t1  = h + big_sig1(e) + ch + ROUND_K[round_q] + sched_q[0];
		t2  = big_sig0(a) + maj;
		// word sixteen rounds ahead, unused in the last sixteen rounds
		w_next = small_sig1(sched_q[14]) + sched_q[9] + small_sig0(sched_q[1]) + sched_q[0];
	end

	// schedule shifts toward slot 0, which holds the word of the current round
	always_ff @(posedge clk) begin
		if (ctrl.push || busy_q) begin
			for (int i = 0; i < NUM_SCHED - 1; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[NUM_SCHED-1] <= busy_q ? w_next : ctrl.push_word;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			work_q <= chain;
		end else if (busy_q) begin
			work_q <= {g, f, e, d + t1, c, b, a, t1 + t2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
		end else if (ctrl.start) begin
			busy_q  <= 1'b1;
			round_q <= '0;
		end else if (busy_q) begin
			round_q <= round_q + 1'b1;
			if (round_q == LAST_ROUND) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign work      = work_q;
	assign stat.done = busy_q && (round_q == LAST_ROUND);

endmodule

// ===== dv/sha256_digest_checker.sv =====
// ---------------------------------------------------------------------------
// sha256_digest_checker
// Watches the message and digest channels of the hasher. Every accepted
// message word goes into a local SHA-256 (padding, length, compression);
// a last word queues the eight expected digest items, which are compared
// field by field with the digest items the block hands out.
// ---------------------------------------------------------------------------
module sha256_digest_checker
	import sha_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [WORD_W-1:0]  s_tdata,   // message_word
	input  logic [VALID_W-1:0] s_tuser,   // valid_bytes
	input  logic               s_tlast,   // last_word
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [WORD_W-1:0]  m_tdata,   // digest_word
	input  logic [IDX_W-1:0]   m_tuser,   // digest_index
	input  logic               m_tlast,   // digest_done
	output int                 mismatch_count,
	output int                 digest_backlog
);

	localparam word_t SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		word_t            digest_word;
		logic [IDX_W-1:0] digest_index;
		logic             digest_done;
	} digest_item_t;

	word_t        chain_q [8];
	word_t        block_q [16];
	logic [63:0]  msg_bits;
	logic [3:0]   fill_slot;
	digest_item_t digest_fifo [$];

	function automatic word_t ror(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_message();
		chain_q   = SHA_IV;
		msg_bits  = '0;
		fill_slot = '0;
	endtask

	task automatic compress_block();
		word_t sched [64];
		word_t v [8];
		word_t t1, t2;
		for (int r = 0; r < 16; r++)
			sched[r] = block_q[r];
		for (int r = 16; r < 64; r++)
			sched[r] = (ror(sched[r-2], 17) ^ ror(sched[r-2], 19) ^ (sched[r-2] >> 10))
				+ sched[r-7]
				+ (ror(sched[r-15], 7) ^ ror(sched[r-15], 18) ^ (sched[r-15] >> 3))
				+ sched[r-16];
		v = chain_q;
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + sched[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			chain_q[j] = chain_q[j] + v[j];
	endtask

	task automatic load_block_word(input word_t w);
		block_q[fill_slot] = w;
		fill_slot = fill_slot + 4'd1;
		if (fill_slot == 4'd0)
			compress_block();
	endtask

	task automatic absorb_word(input word_t w, input logic [VALID_W-1:0] nvalid, input logic lst);
		int           nbytes;
		word_t        keep;
		digest_item_t item;
		if (!lst) begin
			// every byte of a non-final word counts
			msg_bits = msg_bits + 64'd32;
			load_block_word(w);
		end else begin
			nbytes = (nvalid > 4) ? 4 : int'(nvalid);
			msg_bits = msg_bits + 64'(8 * nbytes);
			if (nbytes == 4) begin
				load_block_word(w);
				load_block_word(32'h8000_0000);
			end else begin
				keep = (nbytes == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nbytes));
				load_block_word((w & keep) | (32'h80 << (24 - 8 * nbytes)));
			end
			while (fill_slot != 4'd14)
				load_block_word(32'h0);
			load_block_word(msg_bits[63:32]);
			load_block_word(msg_bits[31:0]);
			for (int k = 0; k < 8; k++) begin
				item.digest_word  = chain_q[k];
				item.digest_index = k[IDX_W-1:0];
				item.digest_done  = (k == 7);
				digest_fifo.push_back(item);
			end
			restart_message();
		end
	endtask

	always @(posedge clk) begin : watch
		digest_item_t want;
		int           errs;
		errs = 0;
		if (!arst_n) begin
			restart_message();
			digest_fifo.delete();
			mismatch_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (digest_fifo.size() == 0) begin
					$error("digest item with none expected: digest_word %h", m_tdata);
					errs++;
				end else begin
					want = digest_fifo.pop_front();
					if (m_tdata !== want.digest_word) begin
						$error("digest_word expected %h got %h", want.digest_word, m_tdata);
						errs++;
					end
					if (m_tuser !== want.digest_index) begin
						$error("digest_index expected %0d got %0d", want.digest_index, m_tuser);
						errs++;
					end
					if (m_tlast !== want.digest_done) begin
						$error("digest_done expected %b got %b", want.digest_done, m_tlast);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				absorb_word(s_tdata, s_tuser, s_tlast);
			mismatch_count <= mismatch_count + errs;
		end
		digest_backlog <= digest_fifo.size();
	end

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives messages into the SHA-256 hasher: a few directed messages on the
// padding edges, then random messages under four idle/stall mixes. The
// checker predicts and compares the digests; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench
	import sha_pkg::*;
;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 100;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [WORD_W-1:0]  s_tdata  = '0;   // message_word
	logic [VALID_W-1:0] s_tuser  = '0;   // valid_bytes
	logic               s_tlast  = 1'b0; // last_word
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [WORD_W-1:0]  m_tdata;         // digest_word
	logic [IDX_W-1:0]   m_tuser;         // digest_index
	logic               m_tlast;         // digest_done

	int          mismatch_count;
	int          digest_backlog;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          words_sent     = 0;
	int unsigned cycle_count    = 0;

	always #1 clk = ~clk;

	sha256_message_hasher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sha256_digest_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.digest_backlog (digest_backlog)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_word(input word_t w, input logic [VALID_W-1:0] nvalid, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= nvalid;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// hold the sender off until every queued digest item has come out
	task automatic wait_digests_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (digest_backlog != 0);
	endtask

	initial begin
		int pick;
		int n_words;
		int phase_end;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then one-word messages with every byte count
		send_word(32'h0, 3'd0, 1'b1);
		for (int v = 1; v < 8; v++)
			send_word(32'hffff_ffff, v[VALID_W-1:0], 1'b1);
		// short count on a non-final word still takes all four bytes
		send_word(32'h0123_4567, 3'd1, 1'b0);
		send_word(32'h89ab_cdef, 3'd0, 1'b1);
		// 14 full words: length no longer fits, padding spills into a second block
		for (int i = 0; i < 13; i++)
			send_word(32'h0, 3'd4, 1'b0);
		send_word(32'hffff_ffff, 3'd4, 1'b1);
		wait_digests_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 49;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 49;
				end
				default: begin
					send_idle_pct  = 9;
					recv_stall_pct = 9;
				end
			endcase
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 60)
					n_words = $urandom_range(20, 1);
				else if (pick < 85)
					// lengths near block edges exercise the extra padding block
					n_words = 16 * $urandom_range(2, 0) + $urandom_range(17, 13);
				else
					n_words = $urandom_range(48, 21);
				for (int i = 1; i < n_words; i++)
					send_word($urandom, VALID_W'($urandom_range(7)), 1'b0);
				send_word($urandom, VALID_W'($urandom_range(7)), 1'b1);
			end
			wait_digests_drained();
		end

		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && digest_backlog == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
